>>> hdl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/irm_pkg.sv
package irm_pkg;

    // geometry
    localparam int MAX_DIM   = 256;
    localparam int DIM_W     = $clog2(MAX_DIM);
    localparam int ADDR_W    = 2 * DIM_W;
    localparam int MEM_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ROW_W     = 9;
    localparam int PIX_W     = 24;
    localparam logic [ROW_W-1:0] MAX_DIM_V = ROW_W'(MAX_DIM);

    // fixed point
    localparam int TRIG_FRAC_BITS = 14;
    localparam int TRIG_W         = TRIG_FRAC_BITS + 2;
    localparam int DELTA_W        = ROW_W + 1;
    localparam int PROD_W         = TRIG_W + DELTA_W;
    localparam int SUM_W          = PROD_W + 1;
    localparam int COORD_W        = SUM_W - TRIG_FRAC_BITS;
    localparam int MID_W          = ROW_W - 1;

    // configuration port
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_DEG  = 2'd2;

    // commands
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // angle reduction: q = floor(|a| * 2912 / 2^20) is at most one short of |a| / 360
    localparam int DEG_W     = 9;
    localparam int QIDX_W    = 7;
    localparam int ANG_MUL_W = 12;
    localparam int ANG_Q_W   = 7;
    localparam int ANG_SHIFT = 20;
    localparam logic [ANG_MUL_W-1:0] ANG_RECIP = 12'd2912;
    localparam logic [DEG_W-1:0] DEG_90  = 9'd90;
    localparam logic [DEG_W-1:0] DEG_180 = 9'd180;
    localparam logic [DEG_W-1:0] DEG_270 = 9'd270;
    localparam logic [DEG_W-1:0] DEG_360 = 9'd360;

    typedef struct packed {
        logic              cmd;
        logic [ROW_W-1:0]  row;
        logic [ROW_W-1:0]  col;
        logic [PIX_W-1:0]  pixel_in;
    } t_in_word;

    typedef struct packed {
        logic [PIX_W-1:0]  pixel_out;
        logic              covered;
    } t_out_word;

    typedef struct packed {
        logic signed [TRIG_W-1:0] cos_v;
        logic signed [TRIG_W-1:0] sin_v;
    } t_trig;

    // quarter-wave sine table, magnitude only
    typedef logic [TRIG_W-2:0] t_sin_tab [0:90];

    localparam logic [47:0] PI_Q46 = 48'hC90FDAA22169;
    localparam logic [15:0] TAYLOR_DEN [1:15] = '{16'd6, 16'd20, 16'd42, 16'd72, 16'd110,
        16'd156, 16'd210, 16'd272, 16'd342, 16'd420, 16'd506, 16'd600, 16'd702, 16'd812,
        16'd930};

    // Q30 Taylor series per whole degree, rounded half up to TRIG_FRAC_BITS
    function automatic t_sin_tab build_sin_tab();
        t_sin_tab    tab;
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] v;
        for (int d = 0; d <= 90; d++) begin
            x = (64'(d) * 64'(PI_Q46)) / 64'd180;
            x = (x + 64'd32768) >> 16;
            term = x;
            sum = x;
            for (int k = 1; k < 16; k++) begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = term / 64'(TAYLOR_DEN[k]);
                if (k % 2 == 1) begin
                    sum = (sum >= term) ? sum - term : 64'd0;
                end else begin
                    sum = sum + term;
                end
            end
            v = (sum + (64'd1 << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS);
            tab[d] = v[TRIG_W-2:0];
        end
        return tab;
    endfunction

    localparam t_sin_tab SIN_TAB = build_sin_tab();

    // sine of d degrees, 0 <= d < 360, by quadrant symmetry
    function automatic logic signed [TRIG_W-1:0] sin_deg(input logic [DEG_W-1:0] d);
        logic [DEG_W-1:0]  idx;
        logic              neg;
        logic [TRIG_W-1:0] mag;
        if (d <= DEG_90) begin
            idx = d;
            neg = 1'b0;
        end else if (d <= DEG_180) begin
            idx = DEG_180 - d;
            neg = 1'b0;
        end else if (d <= DEG_270) begin
            idx = d - DEG_180;
            neg = 1'b1;
        end else begin
            idx = DEG_360 - d;
            neg = 1'b1;
        end
        mag = {1'b0, SIN_TAB[idx[QIDX_W-1:0]]};
        return neg ? -$signed(mag) : $signed(mag);
    endfunction

endpackage

>>> hdl/image_rotate_inverse_map.sv
// Inverse-mapping image rotation, nearest neighbor, with a 256 x 256 RGB888 frame store.
// Input channel (i_in_valid / o_in_ready / i_in_word) carries one word per item:
//   cmd = load  writes pixel_in at (row, col); rows or columns of 256 and up are dropped.
//   cmd = query rotates output pixel (row, col) of the 2M x 2M square back into the source
//               and returns one word on the output channel (o_out_valid / i_out_ready).
// Loads return nothing. Results leave in the order the queries came in.
// Config port: i_cfg_we with i_cfg_idx / i_cfg_data writes height, width or angle, with no
//   wait. Write it only while no query is in flight.
// Pipeline: seven register stages (input, offsets, trig, products, sums,
//   truncate/compare/address, store read). Throughput: one word per cycle unless the
//   output stalls; the single store port reads for every item and writes for a load.
// After its write the angle is reduced mod 360 in the quotient and reduced-degree registers;
//   cos/sin come from a quarter-wave table and are read by the pipeline's third stage.
// Backpressure: every stage moves when the one after it is empty or moving, so bubbles
//   close up and new words keep entering while a finished result waits, until the stages fill.
// Reset: pipeline empties, height and width go to 256 and the angle to 0. Store contents
//   stay undefined until written; there is no clearing pass.

`include "assert_macros.svh"

module image_rotate_inverse_map (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  irm_pkg::t_in_word              i_in_word,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output irm_pkg::t_out_word             o_out_word,
    input  logic                           i_cfg_we,
    input  logic [irm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [irm_pkg::CFG_W-1:0]      i_cfg_data
);

    localparam int RW = irm_pkg::ROW_W;
    localparam int AW = irm_pkg::ADDR_W;
    localparam int DW = irm_pkg::DIM_W;
    localparam int PW = irm_pkg::PIX_W;
    localparam int TW = irm_pkg::TRIG_W;
    localparam int EW = irm_pkg::DELTA_W;
    localparam int XW = irm_pkg::PROD_W;
    localparam int SW = irm_pkg::SUM_W;
    localparam int CW = irm_pkg::COORD_W;
    localparam int MW = irm_pkg::MID_W;
    localparam int FB = irm_pkg::TRIG_FRAC_BITS;

    // ---------------- configuration ----------------
    logic [RW-1:0]   r_h;
    logic [RW-1:0]   r_w;
    logic            angle_we;
    irm_pkg::t_trig  trig;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h <= irm_pkg::MAX_DIM_V;
            r_w <= irm_pkg::MAX_DIM_V;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                irm_pkg::CFG_SRC_HEIGHT: r_h <= i_cfg_data[RW-1:0];
                irm_pkg::CFG_SRC_WIDTH:  r_w <= i_cfg_data[RW-1:0];
                default: ;
            endcase
        end
    end

    assign angle_we = i_cfg_we && (i_cfg_idx == irm_pkg::CFG_ANGLE_DEG);

    irm_angle u_angle (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (angle_we),
        .i_angle (i_cfg_data),
        .o_trig  (trig)
    );

    // saturated dimensions, larger side M, square side 2M
    logic [RW-1:0] h_sat;
    logic [RW-1:0] w_sat;
    logic [RW-1:0] m_dim;
    logic [RW:0]   two_m;

    assign h_sat = (r_h > irm_pkg::MAX_DIM_V) ? irm_pkg::MAX_DIM_V : r_h;
    assign w_sat = (r_w > irm_pkg::MAX_DIM_V) ? irm_pkg::MAX_DIM_V : r_w;
    assign m_dim = (h_sat > w_sat) ? h_sat : w_sat;
    assign two_m = {m_dim, 1'b0};

    // ---------------- stage ready chain ----------------
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7;

    assign rdy7 = !o_out_valid || i_out_ready;
    assign rdy6 = !r_v6 || rdy7;
    assign rdy5 = !r_v5 || rdy6;
    assign rdy4 = !r_v4 || rdy5;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;
    assign o_in_ready = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_in_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
            if (rdy5) r_v5 <= r_v4;
            if (rdy6) r_v6 <= r_v5;
            if (rdy7) r_v7 <= r_v6;
        end
    end

    // ---------------- payload stages ----------------
    irm_pkg::t_in_word r_in1;

    // load side rides along to the store stage
    logic          r_cmd2, r_cmd3, r_cmd4, r_cmd5, r_cmd6, r_cmd7;
    logic [PW-1:0] r_pix2, r_pix3, r_pix4, r_pix5, r_pix6;
    logic [AW-1:0] r_ladr2, r_ladr3, r_ladr4, r_ladr5;
    logic          r_lok2, r_lok3, r_lok4, r_lok5, r_lok6;
    logic          r_inside2, r_inside3, r_inside4, r_inside5;

    logic signed [EW-1:0] r_di2, r_dj2, r_di3, r_dj3;
    logic [MW-1:0]        r_mid2, r_mid3, r_mid4;
    logic signed [TW-1:0] r_cos3, r_sin3;
    logic signed [XW-1:0] r_cdi4, r_sdj4, r_sdi4, r_cdj4;
    logic signed [SW-1:0] r_sxs5, r_sys5;
    logic [AW-1:0]        r_addr6;
    logic                 r_cov6, r_cov7;
    logic [PW-1:0]        r_rd7;

    // stage 1 -> 2 combinational
    logic              n_inside2;
    logic              n_lok2;
    logic signed [EW:0] di_full;
    logic signed [EW:0] dj_full;

    assign n_inside2 = ({1'b0, r_in1.row} < two_m) && ({1'b0, r_in1.col} < two_m);
    assign n_lok2    = (r_in1.row < irm_pkg::MAX_DIM_V) && (r_in1.col < irm_pkg::MAX_DIM_V);
    assign di_full   = $signed({2'b00, r_in1.row}) - $signed({2'b00, m_dim});
    assign dj_full   = $signed({2'b00, r_in1.col}) - $signed({2'b00, m_dim});

    // stage 4 -> 5 combinational: mid * 2^F plus the rotated offsets
    logic signed [SW-1:0] mid_q;
    logic signed [SW-1:0] n_sxs;
    logic signed [SW-1:0] n_sys;

    assign mid_q = $signed(SW'({r_mid4, {FB{1'b0}}}));
    assign n_sxs = mid_q + SW'(r_cdi4) - SW'(r_sdj4);
    assign n_sys = mid_q + SW'(r_sdi4) + SW'(r_cdj4);

    // stage 5 -> 6 combinational: truncate toward zero, bounds, address
    logic signed [SW-1:0] sxb;
    logic signed [SW-1:0] syb;
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic                 n_cov6;
    logic [AW-1:0]        n_addr6;

    assign sxb = r_sxs5 + (r_sxs5[SW-1] ? SW'((1 << FB) - 1) : SW'(0));
    assign syb = r_sys5 + (r_sys5[SW-1] ? SW'((1 << FB) - 1) : SW'(0));
    assign sx  = sxb[SW-1:FB];
    assign sy  = syb[SW-1:FB];
    assign n_cov6 = r_inside5
                 && !sx[CW-1] && (sx < $signed(CW'(h_sat)))
                 && !sy[CW-1] && (sy < $signed(CW'(w_sat)));
    assign n_addr6 = (r_cmd5 == irm_pkg::CMD_QUERY) ? {sx[DW-1:0], sy[DW-1:0]} : r_ladr5;

    always_ff @(posedge i_clk) begin
        if (rdy1) r_in1 <= i_in_word;

        if (rdy2) begin
            r_cmd2    <= r_in1.cmd;
            r_pix2    <= r_in1.pixel_in;
            r_ladr2   <= {r_in1.row[DW-1:0], r_in1.col[DW-1:0]};
            r_lok2    <= n_lok2;
            r_inside2 <= n_inside2;
            r_di2     <= di_full[EW-1:0];
            r_dj2     <= dj_full[EW-1:0];
            r_mid2    <= m_dim[RW-1:1];
        end

        if (rdy3) begin
            r_cmd3    <= r_cmd2;
            r_pix3    <= r_pix2;
            r_ladr3   <= r_ladr2;
            r_lok3    <= r_lok2;
            r_inside3 <= r_inside2;
            r_di3     <= r_di2;
            r_dj3     <= r_dj2;
            r_mid3    <= r_mid2;
            r_cos3    <= trig.cos_v;
            r_sin3    <= trig.sin_v;
        end

        if (rdy4) begin
            r_cmd4    <= r_cmd3;
            r_pix4    <= r_pix3;
            r_ladr4   <= r_ladr3;
            r_lok4    <= r_lok3;
            r_inside4 <= r_inside3;
            r_mid4    <= r_mid3;
            r_cdi4    <= r_cos3 * r_di3;
            r_sdj4    <= r_sin3 * r_dj3;
            r_sdi4    <= r_sin3 * r_di3;
            r_cdj4    <= r_cos3 * r_dj3;
        end

        if (rdy5) begin
            r_cmd5    <= r_cmd4;
            r_pix5    <= r_pix4;
            r_ladr5   <= r_ladr4;
            r_lok5    <= r_lok4;
            r_inside5 <= r_inside4;
            r_sxs5    <= n_sxs;
            r_sys5    <= n_sys;
        end

        if (rdy6) begin
            r_cmd6  <= r_cmd5;
            r_pix6  <= r_pix5;
            r_lok6  <= r_lok5;
            r_cov6  <= n_cov6;
            r_addr6 <= n_addr6;
        end

        if (rdy7) begin
            r_cmd7 <= r_cmd6;
            r_cov7 <= r_cov6;
        end
    end

    // ---------------- frame store ----------------
    // Loads write and queries read at the same stage, so program order holds
    // without forwarding.
    logic [PW-1:0] mem [0:irm_pkg::MEM_DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (r_v6 && rdy7) begin
            if (r_cmd6 == irm_pkg::CMD_LOAD && r_lok6) begin
                mem[r_addr6] <= r_pix6;
            end
            r_rd7 <= mem[r_addr6];
        end
    end

    // ---------------- output ----------------
    assign o_out_valid          = r_v7 && (r_cmd7 == irm_pkg::CMD_QUERY);
    assign o_out_word.pixel_out = r_cov7 ? r_rd7 : '0;
    assign o_out_word.covered   = r_cov7;

    `ASSERT_IMPL(a_uncov_zero, i_clk, i_rst_n, o_out_valid && !o_out_word.covered, o_out_word.pixel_out == '0, "uncovered word carries a pixel")
    `ASSERT_IMPL(a_cov_row, i_clk, i_rst_n, r_v6 && r_cov6 && r_cmd6 == irm_pkg::CMD_QUERY, {1'b0, r_addr6[AW-1:DW]} < h_sat, "covered row beyond height")
    `ASSERT_NEXT(a_rd_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(r_rd7), "store read data lost under stall")

endmodule

>>> hdl/irm_angle.sv
`include "assert_macros.svh"

module irm_angle (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_we,
    input  logic [irm_pkg::CFG_W-1:0]  i_angle,
    output irm_pkg::t_trig             o_trig
);

    logic                                           r_neg;
    logic [irm_pkg::CFG_W-1:0]                      r_abs;
    logic [irm_pkg::ANG_Q_W-1:0]                    r_q;
    logic [irm_pkg::DEG_W-1:0]                      r_dred;
    logic [irm_pkg::DEG_W-1:0]                      n_dred;
    logic [irm_pkg::CFG_W-1:0]                      abs_in;
    logic [irm_pkg::CFG_W+irm_pkg::ANG_MUL_W-1:0]   prod;
    logic [irm_pkg::CFG_W-1:0]                      rem_full;
    logic [irm_pkg::DEG_W:0]                        rem;
    logic [irm_pkg::DEG_W:0]                        rem_fix;
    logic [irm_pkg::DEG_W-1:0]                      cos_idx;

    // stage A: magnitude and approximate quotient, taken at the write
    assign abs_in = i_angle[irm_pkg::CFG_W-1] ? (~i_angle + 1'b1) : i_angle;
    assign prod   = {{irm_pkg::ANG_MUL_W{1'b0}}, abs_in}
                  * {{irm_pkg::CFG_W{1'b0}}, irm_pkg::ANG_RECIP};

    // stage B: remainder, one correction, C sign rule folded to 0..359
    assign rem_full = r_abs - (irm_pkg::CFG_W'(r_q) * irm_pkg::CFG_W'(irm_pkg::DEG_360));
    assign rem      = rem_full[irm_pkg::DEG_W:0];
    assign rem_fix  = (rem >= {1'b0, irm_pkg::DEG_360}) ? rem - {1'b0, irm_pkg::DEG_360} : rem;
    assign n_dred   = (r_neg && rem_fix != '0)
                    ? irm_pkg::DEG_W'({1'b0, irm_pkg::DEG_360} - rem_fix)
                    : rem_fix[irm_pkg::DEG_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_neg  <= 1'b0;
            r_abs  <= '0;
            r_q    <= '0;
            r_dred <= '0;
        end else begin
            if (i_we) begin
                r_neg <= i_angle[irm_pkg::CFG_W-1];
                r_abs <= abs_in;
                r_q   <= prod[irm_pkg::ANG_SHIFT +: irm_pkg::ANG_Q_W];
            end
            r_dred <= n_dred;
        end
    end

    // cos(d) = sin(d + 90)
    assign cos_idx = (r_dred >= irm_pkg::DEG_270) ? r_dred - irm_pkg::DEG_270
                                                  : r_dred + irm_pkg::DEG_90;
    assign o_trig.sin_v = irm_pkg::sin_deg(r_dred);
    assign o_trig.cos_v = irm_pkg::sin_deg(cos_idx);

    `ASSERT_IMPL(a_deg_range, i_clk, i_rst_n, 1'b1, r_dred < irm_pkg::DEG_360, "angle out of range")

endmodule
